@@ src/stbs_pkg.sv @@
// shared constants, types and helpers for the sorted table binary search block
package stbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int WORD_WIDTH  = 32;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = 10;
	localparam int POS_W  = 10;
	localparam int VAL_W  = 32;
	localparam int CFG_W  = 11;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_DONE
	} stbs_state_t;

	typedef struct packed {
		logic load_word;
		logic start;
		logic step;
		logic rd_en;
		logic latch;
		logic latch_found;
		logic publish;
	} stbs_cmd_t;

	typedef struct packed {
		logic empty;
		logic hit;
	} stbs_stat_t;

	// low WORD_WIDTH bits of the sign-extended input word
	function automatic logic [WORD_WIDTH-1:0] to_word(input logic [VAL_W-1:0] v);
		logic [63:0] ext;
		ext = {{(64 - VAL_W){v[VAL_W-1]}}, v};
		return ext[WORD_WIDTH-1:0];
	endfunction

endpackage

@@ src/stbs_req_if.sv @@
// request channel: load or search items
interface stbs_req_if
	import stbs_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SLOT_W-1:0] slot;
	logic [VAL_W-1:0]  value;

	modport source (output valid, opcode, slot, value, input ready);
	modport sink (input valid, opcode, slot, value, output ready);
endinterface

@@ src/stbs_rsp_if.sv @@
// response channel: search results
interface stbs_rsp_if
	import stbs_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink (input valid, found, position, output ready);
endinterface

@@ src/stbs_cfg_if.sv @@
// configuration write channel for the entry count register
interface stbs_cfg_if
	import stbs_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ src/stbs_ram.sv @@
// generic single write port, single read port ram with registered read
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ src/stbs_datapath.sv @@
// table storage, search bounds, probe compare and result registers
module stbs_datapath
	import stbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  stbs_cmd_t         cmd,
	output stbs_stat_t        stat,
	input  logic [SLOT_W-1:0] slot,
	input  logic [VAL_W-1:0]  value,
	input  logic              cfg_wr,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              found,
	output logic [POS_W-1:0]  position
);
	logic [CFG_W-1:0]      entry_count_q;
	logic [WORD_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;       // exclusive upper bound
	logic [ADDR_W-1:0]     mid_q;
	logic                  res_found_q;
	logic                  found_q;
	logic [POS_W-1:0]      pos_q;

	logic [WORD_WIDTH-1:0] rd_data;
	logic [CNT_W-1:0]      count_sat;
	logic                  greater;
	logic [CNT_W-1:0]      lo_n;
	logic [CNT_W-1:0]      hi_n;
	logic [CNT_W-1:0]      lo_sel;
	logic [CNT_W-1:0]      hi_sel;
	logic [CNT_W:0]        mid_sum;
	logic [ADDR_W-1:0]     mid_c;
	logic                  wr_ok;

	always_comb begin
		if (32'(entry_count_q) > TABLE_DEPTH) begin
			count_sat = CNT_W'(TABLE_DEPTH);
		end else begin
			count_sat = CNT_W'(entry_count_q);
		end
	end

	// loads beyond the table depth are dropped
	assign wr_ok = cmd.load_word && (32'(slot) < TABLE_DEPTH);

	assign stat.hit = (rd_data == key_q);
	assign greater  = $signed(rd_data) > $signed(key_q);

	always_comb begin
		if (greater) begin
			lo_n = lo_q;
			hi_n = CNT_W'(mid_q);
		end else begin
			lo_n = CNT_W'(mid_q) + CNT_W'(1);
			hi_n = hi_q;
		end
		lo_sel     = cmd.step ? lo_n : lo_q;
		hi_sel     = cmd.step ? hi_n : hi_q;
		stat.empty = !(lo_sel < hi_sel);
		// floor((low + high) / 2) with high = hi_sel - 1
		mid_sum    = {1'b0, lo_sel} + {1'b0, hi_sel} - (CNT_W + 1)'(1);
		mid_c      = ADDR_W'(mid_sum[CNT_W:1]);
	end

	stbs_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (ADDR_W'(slot)),
		.wr_data (to_word(value)),
		.rd_en   (cmd.rd_en),
		.rd_addr (mid_c),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr) begin
			entry_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= to_word(value);
			lo_q  <= '0;
			hi_q  <= count_sat;
		end else if (cmd.step) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (cmd.rd_en) begin
			mid_q <= mid_c;
		end
		if (cmd.latch) begin
			res_found_q <= cmd.latch_found;
		end
		if (cmd.publish) begin
			found_q <= res_found_q;
			pos_q   <= res_found_q ? POS_W'(mid_q) : '0;
		end
	end

	assign found    = found_q;
	assign position = pos_q;
endmodule

@@ src/stbs_ctrl.sv @@
// search sequencer and response valid tracking
module stbs_ctrl
	import stbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_opcode,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  stbs_stat_t stat,
	output stbs_cmd_t  cmd
);
	stbs_state_t state_q;
	stbs_state_t state_n;
	logic        rsp_valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req_opcode == OP_SEARCH) begin
					state_n = ST_START;
				end
			end
			ST_START: begin
				state_n = stat.empty ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				if (stat.hit || stat.empty) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_word = req_valid && req_opcode == OP_LOAD;
				cmd.start     = req_valid && req_opcode == OP_SEARCH;
			end
			ST_START: begin
				cmd.rd_en = !stat.empty;
				cmd.latch = stat.empty;
			end
			ST_PROBE: begin
				// step must not depend on empty: empty is computed from the stepped bounds
				cmd.step        = !stat.hit;
				cmd.latch       = stat.hit || stat.empty;
				cmd.latch_found = stat.hit;
				cmd.rd_en       = !stat.hit && !stat.empty;
			end
			ST_DONE: begin
				cmd.publish = !rsp_valid_q || rsp_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule

@@ src/sorted_table_binary_search.sv @@
// a load is written to the table on acceptance; a search runs the start, probe
// and done states, at most ceil(log2(entry_count + 1)) probes, then raises response
// valid; throughput: one search at a time, the next request accepted once the search
// has published its result, later while an earlier result is stalled; set by the
// single table read port (one probe per cycle); loads accepted every cycle while idle
// reset: arst_n clears the sequencer, response valid and entry_count to 0;
// table contents are undefined until loaded
module sorted_table_binary_search
	import stbs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	stbs_req_if.sink   req,
	stbs_rsp_if.source rsp,
	stbs_cfg_if.sink   cfg
);
	stbs_cmd_t  cmd;
	stbs_stat_t stat;

	assign cfg.ready = 1'b1;

	stbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	stbs_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.slot     (req.slot),
		.value    (req.value),
		.cfg_wr   (cfg.valid),
		.cfg_data (cfg.data),
		.found    (rsp.found),
		.position (rsp.position)
	);
endmodule
